// File: src/stsm_pkg.sv
// Shared types, constants and helper functions of the timer slot manager.
package stsm_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_FIRST = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    MODE_POLL     = 2'd0,
    MODE_SCHEDULE = 2'd1,
    MODE_CANCEL   = 2'd2,
    MODE_QUERY    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] now_ms;
    logic [31:0] delay_ms;
    logic [31:0] period_ms;
    logic [3:0]  slot;
    logic [31:0] gen_id;
  } in_item_t;

  typedef struct packed {
    logic        fired;
    logic [3:0]  fired_slot;
    logic        granted;
    logic [3:0]  granted_slot;
    logic [31:0] granted_id;
    logic        is_active;
    logic [3:0]  armed_count;
  } out_item_t;

  function automatic logic [3:0] to_field4(input logic [SLOT_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[3:0];
  endfunction

  function automatic logic [3:0] sat4(input logic [SLOT_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'd15) ? 4'hF : w[3:0];
  endfunction

endpackage

// File: src/stsm_if.sv
// Valid and ready channel interfaces for command and result transfers.
interface stsm_in_if;
  logic                valid;
  logic                ready;
  stsm_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stsm_out_if;
  logic                valid;
  logic                ready;
  stsm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/software_timer_slot_manager.sv
// Timer slot bank with a sequential scan over the slots for poll and schedule.
// One command transfer gives one result transfer. Poll and schedule pass from
// idle, which takes the command, through a scan of slots 1 to NUM_SLOTS - 1,
// one slot per cycle through the single due time comparator, to apply, which
// updates the slot and loads the result register once it is free. Cancel and
// query go to apply directly. A new command is taken once the block is back in
// idle, even while the previous result still waits in the output register.
module software_timer_slot_manager (
  input  logic             clk_i,
  input  logic             rst_ni,
  stsm_in_if.sink          in_i,
  stsm_out_if.source       out_o
);

  localparam int unsigned SW = stsm_pkg::SLOT_W;
  localparam int unsigned NS = stsm_pkg::NUM_SLOTS;

  stsm_pkg::state_e    state_q, state_d;
  stsm_pkg::in_item_t  req_q;
  stsm_pkg::out_item_t res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic [SW-1:0]       idx_q, idx_d;
  logic                found_q, found_d;
  logic [SW-1:0]       best_q, best_d;
  logic [31:0]         best_due_q, best_due_d;
  logic [31:0]         id_ctr_q, id_ctr_d;
  logic [SW-1:0]       count_q, count_d;
  logic [NS-1:0]       armed_q, armed_d;

  logic [31:0]         due_q    [NS];
  logic [31:0]         period_q [NS];
  logic [31:0]         id_q     [NS];

  logic                in_ready;
  logic                in_xfer;
  logic [31:0]         hslot_w;
  logic                hslot_ok;
  logic [SW-1:0]       hslot_idx;
  logic [SW-1:0]       rd_addr;
  logic                rd_armed;
  logic [31:0]         rd_due;
  logic [31:0]         rd_period;
  logic [31:0]         rd_id;
  logic [31:0]         cmp_a, cmp_b;
  logic                cmp_lt;
  logic [31:0]         add_b, add_sum;
  logic [31:0]         id_inc, id_next;
  logic                wr_due_en, wr_all_en;
  logic                id_match;

  assign in_xfer   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

  assign hslot_w   = 32'(req_q.slot);
  assign hslot_ok  = hslot_w < NS;
  assign hslot_idx = hslot_w[SW-1:0];

  always_comb begin
    if (state_q == stsm_pkg::ST_SCAN) begin
      rd_addr = idx_q;
    end else if (req_q.mode == stsm_pkg::MODE_CANCEL || req_q.mode == stsm_pkg::MODE_QUERY) begin
      rd_addr = hslot_idx;
    end else begin
      rd_addr = best_q;
    end
  end

  assign rd_armed  = armed_q[rd_addr];
  assign rd_due    = due_q[rd_addr];
  assign rd_period = period_q[rd_addr];
  assign rd_id     = id_q[rd_addr];
  assign id_match  = rd_armed && (rd_id == req_q.gen_id);

  // Shared comparator and adder.
  always_comb begin
    if (state_q == stsm_pkg::ST_SCAN) begin
      cmp_a = rd_due;
    end else begin
      cmp_a = req_q.now_ms;
    end
    cmp_b  = best_due_q;
    cmp_lt = cmp_a < cmp_b;
    add_b  = (req_q.mode == stsm_pkg::MODE_SCHEDULE) ? req_q.delay_ms : rd_period;
    add_sum = req_q.now_ms + add_b;
  end

  assign id_inc  = id_ctr_q + 32'd1;
  assign id_next = (id_inc == 32'd0) ? 32'd1 : id_inc;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    found_d     = found_q;
    best_d      = best_q;
    best_due_d  = best_due_q;
    id_ctr_d    = id_ctr_q;
    count_d     = count_q;
    armed_d     = armed_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    in_ready    = 1'b0;
    wr_due_en   = 1'b0;
    wr_all_en   = 1'b0;

    unique case (state_q)
      stsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          idx_d   = stsm_pkg::SLOT_FIRST;
          found_d = 1'b0;
          if (in_i.data.mode == stsm_pkg::MODE_POLL ||
              in_i.data.mode == stsm_pkg::MODE_SCHEDULE) begin
            state_d = stsm_pkg::ST_SCAN;
          end else begin
            state_d = stsm_pkg::ST_APPLY;
          end
        end
      end
      stsm_pkg::ST_SCAN: begin
        unique case (req_q.mode)
          stsm_pkg::MODE_POLL: begin
            if (rd_armed && (!found_q || cmp_lt)) begin
              found_d    = 1'b1;
              best_d     = idx_q;
              best_due_d = rd_due;
            end
          end
          stsm_pkg::MODE_SCHEDULE: begin
            if (!rd_armed && !found_q) begin
              found_d = 1'b1;
              best_d  = idx_q;
            end
          end
          default: begin
          end
        endcase
        if (idx_q == stsm_pkg::SLOT_LAST) begin
          state_d = stsm_pkg::ST_APPLY;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end
      stsm_pkg::ST_APPLY: begin
        if (!out_valid_q || out_o.ready) begin
          res_d       = '0;
          out_valid_d = 1'b1;
          state_d     = stsm_pkg::ST_IDLE;
          unique case (req_q.mode)
            stsm_pkg::MODE_POLL: begin
              if (found_q && !cmp_lt) begin
                res_d.fired      = 1'b1;
                res_d.fired_slot = stsm_pkg::to_field4(best_q);
                if (rd_period != 32'd0) begin
                  wr_due_en = 1'b1;
                end else begin
                  armed_d[best_q] = 1'b0;
                  count_d = count_q - SW'(1);
                end
              end
            end
            stsm_pkg::MODE_SCHEDULE: begin
              if (found_q) begin
                id_ctr_d           = id_next;
                wr_all_en          = 1'b1;
                armed_d[best_q]    = 1'b1;
                count_d            = count_q + SW'(1);
                res_d.granted      = 1'b1;
                res_d.granted_slot = stsm_pkg::to_field4(best_q);
                res_d.granted_id   = id_next;
              end
            end
            stsm_pkg::MODE_CANCEL: begin
              if (hslot_ok && id_match) begin
                armed_d[hslot_idx] = 1'b0;
                count_d = count_q - SW'(1);
              end
            end
            stsm_pkg::MODE_QUERY: begin
              res_d.is_active = hslot_ok && (req_q.gen_id != 32'd0) && id_match;
            end
            default: begin
            end
          endcase
          res_d.armed_count = stsm_pkg::sat4(count_d);
        end
      end
      default: begin
        state_d = stsm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stsm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= stsm_pkg::SLOT_FIRST;
      found_q     <= 1'b0;
      best_q      <= '0;
      id_ctr_q    <= '0;
      count_q     <= '0;
      armed_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      best_q      <= best_d;
      id_ctr_q    <= id_ctr_d;
      count_q     <= count_d;
      armed_q     <= armed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_due_q <= best_due_d;
    res_q      <= res_d;
    if (in_xfer) begin
      req_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_due_en || wr_all_en) begin
      due_q[best_q] <= add_sum;
    end
    if (wr_all_en) begin
      period_q[best_q] <= req_q.period_ms;
      id_q[best_q]     <= id_next;
    end
  end

  a_slot0_never_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q[0])
    else $error("Reserved slot 0 is armed.");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == SW'($countones(armed_q)))
    else $error("Armed count disagrees with the armed slots.");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != stsm_pkg::ST_IDLE)
    else $error("Sequencer idle right after a command transfer.");

  a_grant_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.granted |-> res_q.granted_id != 32'd0)
    else $error("Granted generation id is zero.");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $countones({res_q.fired, res_q.granted, res_q.is_active}) <= 1)
    else $error("Result reports more than one kind of outcome.");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the timer slot manager with a built-in slot bank predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    HANDLE_GIVEN,
    HANDLE_LIVE,
    HANDLE_LIVE_WRONG,
    HANDLE_OLD
  } handle_src_e;

  typedef struct {
    stsm_pkg::in_item_t cmd;
    handle_src_e        src;
    bit                 drain;
  } queued_cmd_t;

  typedef struct {
    logic [3:0]  slot;
    logic [31:0] id;
  } timer_handle_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  stsm_in_if  cmd_if ();
  stsm_out_if res_if ();

  software_timer_slot_manager dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  always #10 clk_i = ~clk_i;

  queued_cmd_t         cmd_backlog[$];
  stsm_pkg::out_item_t predicted_replies[$];
  timer_handle_t       grant_history[$];
  int                  mismatch_count = 0;
  int                  reply_index = 0;

  logic [31:0] slot_due    [stsm_pkg::NUM_SLOTS];
  logic [31:0] slot_period [stsm_pkg::NUM_SLOTS];
  logic [31:0] slot_gen    [stsm_pkg::NUM_SLOTS];
  logic [31:0] gen_counter;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("reply %0d field %s got 0x%0h expected 0x%0h",
                                reply_index, name, got, want));
  endtask

  function automatic void clear_slot(input int s);
    slot_due[s]    = '0;
    slot_period[s] = '0;
    slot_gen[s]    = '0;
  endfunction

  function automatic stsm_pkg::out_item_t timer_bank_apply(input stsm_pkg::in_item_t c);
    stsm_pkg::out_item_t r;
    int                  best;
    int                  armed;
    timer_handle_t       h;
    r = '0;
    best = 0;
    armed = 0;
    case (c.mode)
      stsm_pkg::MODE_POLL: begin
        for (int s = 1; s < stsm_pkg::NUM_SLOTS; s++)
          if (slot_gen[s] != 0 && (best == 0 || slot_due[s] < slot_due[best]))
            best = s;
        if (best != 0 && slot_due[best] <= c.now_ms) begin
          r.fired      = 1'b1;
          r.fired_slot = 4'(best);
          if (slot_period[best] != 0)
            slot_due[best] = c.now_ms + slot_period[best];
          else
            clear_slot(best);
        end
      end
      stsm_pkg::MODE_SCHEDULE: begin
        for (int s = 1; s < stsm_pkg::NUM_SLOTS; s++)
          if (!r.granted && slot_gen[s] == 0) begin
            gen_counter = gen_counter + 32'd1;
            if (gen_counter == 0)
              gen_counter = 32'd1;
            slot_due[s]    = c.now_ms + c.delay_ms;
            slot_period[s] = c.period_ms;
            slot_gen[s]    = gen_counter;
            r.granted      = 1'b1;
            r.granted_slot = 4'(s);
            r.granted_id   = gen_counter;
            h.slot = 4'(s);
            h.id   = gen_counter;
            grant_history.push_back(h);
            if (grant_history.size() > 32)
              void'(grant_history.pop_front());
          end
      end
      stsm_pkg::MODE_CANCEL: begin
        if (int'(c.slot) < stsm_pkg::NUM_SLOTS && slot_gen[c.slot] == c.gen_id)
          clear_slot(int'(c.slot));
      end
      default: begin
        if (int'(c.slot) < stsm_pkg::NUM_SLOTS && c.gen_id != 0 &&
            slot_gen[c.slot] == c.gen_id)
          r.is_active = 1'b1;
      end
    endcase
    for (int s = 1; s < stsm_pkg::NUM_SLOTS; s++)
      if (slot_gen[s] != 0)
        armed++;
    r.armed_count = (armed > 15) ? 4'hF : 4'(armed);
    return r;
  endfunction

  function automatic stsm_pkg::in_item_t fill_handle(input queued_cmd_t e);
    stsm_pkg::in_item_t c;
    int                 live[$];
    int                 k;
    c = e.cmd;
    if (e.src == HANDLE_LIVE || e.src == HANDLE_LIVE_WRONG) begin
      for (int s = 1; s < stsm_pkg::NUM_SLOTS; s++)
        if (slot_gen[s] != 0)
          live.push_back(s);
      if (live.size() != 0) begin
        k = live[$urandom_range(0, live.size() - 1)];
        c.slot   = 4'(k);
        c.gen_id = slot_gen[k];
        if (e.src == HANDLE_LIVE_WRONG)
          c.gen_id = c.gen_id ^ (32'd1 << $urandom_range(0, 31));
      end
    end else if (e.src == HANDLE_OLD && grant_history.size() != 0) begin
      k = $urandom_range(0, grant_history.size() - 1);
      c.slot   = grant_history[k].slot;
      c.gen_id = grant_history[k].id;
    end
    return c;
  endfunction

  task automatic queue_cmd(input stsm_pkg::mode_e m, input logic [31:0] now,
                           input logic [31:0] delay,
                           input logic [31:0] period, input logic [3:0] slot,
                           input logic [31:0] id, input handle_src_e src = HANDLE_GIVEN,
                           input bit drain = 1'b0);
    queued_cmd_t e;
    e.cmd.mode      = m;
    e.cmd.now_ms    = now;
    e.cmd.delay_ms  = delay;
    e.cmd.period_ms = period;
    e.cmd.slot      = slot;
    e.cmd.gen_id    = id;
    e.src           = src;
    e.drain         = drain;
    cmd_backlog.push_back(e);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    logic        offer;
    queued_cmd_t nxt;
    int          burst_left;
    int          gap_left;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      cmd_if.data  <= '0;
      burst_left = 0;
      gap_left   = 0;
      for (int s = 0; s < stsm_pkg::NUM_SLOTS; s++)
        clear_slot(s);
      gen_counter = '0;
    end else begin
      offer = cmd_if.valid;
      if (cmd_if.valid && cmd_if.ready) begin
        predicted_replies.push_back(timer_bank_apply(cmd_if.data));
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].drain && predicted_replies.size() != 0)) begin
          nxt = cmd_backlog.pop_front();
          cmd_if.data <= fill_handle(nxt);
          offer = 1'b1;
          if (burst_left <= 1) begin
            if ($urandom_range(0, 5) == 0) begin
              burst_left = $urandom_range(40, 120);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            end
          end else begin
            burst_left--;
          end
        end
      end
      cmd_if.valid <= offer;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : reply_monitor
    stsm_pkg::out_item_t want;
    int                  stall_style;
    int                  stall_span;
    logic [15:0]         stall_bits;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_style = 0;
      stall_span  = 0;
      stall_bits  = 16'hFFFF;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (predicted_replies.size() == 0) begin
          report_mismatch($sformatf("reply %0d arrived with nothing expected", reply_index));
        end else begin
          want = predicted_replies.pop_front();
          check_field("fired", 32'(res_if.data.fired), 32'(want.fired));
          check_field("fired_slot", 32'(res_if.data.fired_slot), 32'(want.fired_slot));
          check_field("granted", 32'(res_if.data.granted), 32'(want.granted));
          check_field("granted_slot", 32'(res_if.data.granted_slot),
                      32'(want.granted_slot));
          check_field("granted_id", res_if.data.granted_id, want.granted_id);
          check_field("is_active", 32'(res_if.data.is_active), 32'(want.is_active));
          check_field("armed_count", 32'(res_if.data.armed_count), 32'(want.armed_count));
        end
        reply_index++;
      end
      if (stall_span == 0) begin
        stall_style = $urandom_range(0, 2);
        stall_span  = $urandom_range(16, 96);
        stall_bits  = 16'($urandom) | 16'h0001;
      end else begin
        stall_span--;
      end
      stall_bits = {stall_bits[0], stall_bits[15:1]};
      case (stall_style)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= stall_bits[0];
        default: res_if.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin : stimulus
    logic [31:0] clk_ms;
    logic [31:0] delay;
    logic [31:0] period;
    int          seg_len;
    int          pick;
    bit          fill;
    bit          drain;
    bit          first_seg;
    handle_src_e src;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    res_if.ready = 1'b0;
    rst_ni = 1'b0;

    queue_cmd(stsm_pkg::MODE_QUERY, 0, 0, 0, 4'd0, 32'd0);
    queue_cmd(stsm_pkg::MODE_CANCEL, 0, 0, 0, 4'd0, 32'd0);
    queue_cmd(stsm_pkg::MODE_POLL, 0, 0, 0, 4'd0, 32'd0);
    queue_cmd(stsm_pkg::MODE_SCHEDULE, 0, 0, 0, 4'd0, 32'd0);
    queue_cmd(stsm_pkg::MODE_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF,
              32'hFFFF_FFFF);
    queue_cmd(stsm_pkg::MODE_POLL, 0, 0, 0, 4'd0, 32'd0);
    queue_cmd(stsm_pkg::MODE_SCHEDULE, 32'd10, 32'd5, 32'd0, 4'd0, 32'd0);
    queue_cmd(stsm_pkg::MODE_SCHEDULE, 32'd5, 32'd10, 32'd7, 4'd0, 32'd0);
    queue_cmd(stsm_pkg::MODE_POLL, 32'd20, 0, 0, 4'd0, 32'd0);
    queue_cmd(stsm_pkg::MODE_POLL, 32'd20, 0, 0, 4'd0, 32'd0);
    queue_cmd(stsm_pkg::MODE_POLL, 32'd20, 0, 0, 4'd0, 32'd0);
    queue_cmd(stsm_pkg::MODE_QUERY, 32'd20, 0, 0, 4'd3, 32'd4);
    queue_cmd(stsm_pkg::MODE_QUERY, 32'd20, 0, 0, 4'd3, 32'd0);
    queue_cmd(stsm_pkg::MODE_QUERY, 32'd20, 0, 0, 4'd0, 32'hFFFF_FFFF);
    queue_cmd(stsm_pkg::MODE_CANCEL, 32'd20, 0, 0, 4'd3, 32'd5);
    queue_cmd(stsm_pkg::MODE_CANCEL, 32'd20, 0, 0, 4'd3, 32'd4);
    queue_cmd(stsm_pkg::MODE_QUERY, 32'd20, 0, 0, 4'd3, 32'd4);
    queue_cmd(stsm_pkg::MODE_POLL, 32'hFFFF_FFFF, 0, 0, 4'd0, 32'd0);
    queue_cmd(stsm_pkg::MODE_CANCEL, 32'hFFFF_FFFF, 0, 0, 4'd2, 32'd1);

    clk_ms    = 32'd100;
    first_seg = 1'b1;
    while (cmd_backlog.size() < 1800) begin
      case ($urandom_range(0, 5))
        0:       clk_ms = $urandom;
        1:       clk_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
        2:       clk_ms = $urandom_range(0, 1000);
        default: ;
      endcase
      fill    = first_seg || ($urandom_range(0, 7) == 0);
      drain   = first_seg || ($urandom_range(0, 3) == 0);
      seg_len = $urandom_range(10, 40);
      for (int i = 0; i < seg_len; i++) begin
        pick = (fill && i < 16) ? 0 : $urandom_range(0, 99);
        case ($urandom_range(0, 9))
          0:       delay = $urandom;
          1:       delay = 32'd0;
          default: delay = $urandom_range(0, 40);
        endcase
        case ($urandom_range(0, 19))
          0:                    period = $urandom;
          1, 2, 3, 4, 5:        period = $urandom_range(1, 30);
          default:              period = 32'd0;
        endcase
        case ($urandom_range(0, 9))
          7:       src = HANDLE_LIVE_WRONG;
          8, 9:    src = HANDLE_OLD;
          default: src = HANDLE_LIVE;
        endcase
        if (pick < 35) begin
          queue_cmd(stsm_pkg::MODE_SCHEDULE, clk_ms, delay, period, 4'($urandom), $urandom,
                    HANDLE_GIVEN, drain);
        end else if (pick < 70) begin
          clk_ms = clk_ms + $urandom_range(0, 15);
          queue_cmd(stsm_pkg::MODE_POLL, clk_ms, delay, period, 4'($urandom), $urandom,
                    HANDLE_GIVEN, drain);
        end else if (pick < 82) begin
          queue_cmd(stsm_pkg::MODE_CANCEL, clk_ms, delay, period, 4'($urandom), $urandom,
                    src, drain);
        end else if (pick < 94) begin
          queue_cmd(stsm_pkg::MODE_QUERY, clk_ms, delay, period, 4'($urandom), $urandom,
                    src, drain);
        end else begin
          queue_cmd(stsm_pkg::mode_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                    4'($urandom), $urandom, HANDLE_GIVEN, drain);
        end
        drain = 1'b0;
      end
      if ($urandom_range(0, 2) == 0)
        repeat (15) queue_cmd(stsm_pkg::MODE_CANCEL, clk_ms, 0, 0, 4'($urandom), $urandom,
                              HANDLE_LIVE);
      first_seg = 1'b0;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (cmd_backlog.size() != 0 || cmd_if.valid);
    while (predicted_replies.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (predicted_replies.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", predicted_replies.size()));

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
